>>> rtl/tx_ring_chunk_submitter_core_defines.svh
// Assertion macros used by the transmit ring submitter top level.
`ifndef TX_RING_CHUNK_SUBMITTER_CORE_DEFINES_SVH
`define TX_RING_CHUNK_SUBMITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TRCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/trcs_pkg.sv
// Types and constants of the transmit ring chunk submitter.
package trcs_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int CHUNK_LIMIT = 512;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int LEN_W       = 10;
    localparam int BLEN_W      = 16;
    localparam int DATA_W      = 8;
    localparam int CMD_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KICK     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_COMPLETE,
        OP_KICK,
        OP_READ
    } op_kind_t;

    typedef enum logic {
        B_EXEC,
        B_FINISH
    } back_state_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [DATA_W-1:0]   data_byte;
        logic                block_first;
        logic                block_last;
        logic [BLEN_W-1:0]   block_len;
        logic                len_zero;
        logic                stack_ready;
        logic                stack_idle;
        logic [PTR_W-1:0]    read_addr;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

>>> rtl/trcs_if.sv
// Item and result channel interfaces of the transmit ring chunk submitter.
interface trcs_item_if import trcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [DATA_W-1:0]   data_byte;
    logic                block_first;
    logic                block_last;
    logic [BLEN_W-1:0]   block_len;
    logic                stack_ready;
    logic                stack_idle;
    logic [PTR_W-1:0]    read_addr;

    modport source (
        output valid, cmd, data_byte, block_first, block_last, block_len,
               stack_ready, stack_idle, read_addr,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_byte, block_first, block_last, block_len,
               stack_ready, stack_idle, read_addr,
        output ready
    );
endinterface

interface trcs_result_if import trcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                accepted;
    logic                submit_valid;
    logic [PTR_W-1:0]    submit_start;
    logic [LEN_W-1:0]    submit_len;
    logic [PTR_W-1:0]    space_left;
    logic [LEN_W-1:0]    inflight_len;
    logic [DATA_W-1:0]   read_data;

    modport source (
        output valid, accepted, submit_valid, submit_start, submit_len,
               space_left, inflight_len, read_data,
        input  ready
    );
    modport sink (
        input  valid, accepted, submit_valid, submit_start, submit_len,
               space_left, inflight_len, read_data,
        output ready
    );
endinterface

>>> rtl/tx_ring_chunk_submitter_core.sv
// Top level of the transmit ring chunk submitter.
//
// Usage:
//   item   - one command per transfer: write byte, transmit complete, kick,
//            or endpoint read. Writes carry block framing and length.
//   result - exactly one result per item, in item order: write status,
//            the chunk handed to the endpoint (if any), free space,
//            bytes in flight, and the byte read on an endpoint read.
// Path: when the back end is free and the result side is not stalled, an item
//   goes from the queue through the back end's execute and finish steps into the result register.
// Flow: the back end finishes each item before it takes the next; its execute
//   step does the pointer and ring memory update and its finish step the chunk
//   computation and the result register load. The 2-entry queue lets the front
//   accept items while the back end works.
// Reset: pointers, in-flight count and block status clear at once; the ring
//   memory is not cleared and holds nothing readable until written.
// Stall: the result register holds until taken; the back end waits, the
//   queue fills, and item ready drops while the queue is full.
`include "tx_ring_chunk_submitter_core_defines.svh"

module tx_ring_chunk_submitter_core import trcs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    trcs_item_if.sink       item,
    trcs_result_if.source   result
);

    logic        push, pop;
    op_t         push_op, head_op;
    queue_stat_t q_stat;

    trcs_front u_front (
        .item    (item),
        .q_stat  (q_stat),
        .push    (push),
        .push_op (push_op)
    );

    trcs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat)
    );

    trcs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head_op (head_op),
        .q_stat  (q_stat),
        .pop     (pop),
        .result  (result)
    );

    `TRCS_ASSERT_NOW(a_submit_tracks_inflight, result.valid && result.submit_valid, (result.inflight_len == result.submit_len) && (result.submit_len != '0), "submitted chunk does not match in-flight length")
    `TRCS_ASSERT_NOW(a_chunk_within_queued, result.valid && result.submit_valid, ({1'b0, result.space_left} + (PTR_W + 1)'(result.submit_len)) <= (PTR_W + 1)'(RING_DEPTH - 1), "chunk exceeds queued bytes")
    `TRCS_ASSERT_NOW(a_idle_submit_zero, result.valid && !result.submit_valid, (result.submit_start == '0) && (result.submit_len == '0), "chunk fields set without submission")
    `TRCS_ASSERT_NEXT(a_full_queue_blocks, q_stat.full && !pop, !item.ready, "item taken while queue full")

endmodule

>>> rtl/trcs_front.sv
// Front end: takes input transfers and classifies them into queued operations.
module trcs_front import trcs_pkg::*; (
    trcs_item_if.sink item,
    input  queue_stat_t q_stat,
    output logic        push,
    output op_t         push_op
);

    op_kind_t kind;

    always_comb
    begin
        case (item.cmd)
            CMD_WRITE:    kind = OP_WRITE;
            CMD_COMPLETE: kind = OP_COMPLETE;
            CMD_KICK:     kind = OP_KICK;
            CMD_READ:     kind = OP_READ;
            default:      kind = OP_KICK;
        endcase
    end

    assign item.ready = !q_stat.full;
    assign push       = item.valid && !q_stat.full;

    always_comb
    begin
        push_op.kind        = kind;
        push_op.data_byte   = item.data_byte;
        push_op.block_first = item.block_first;
        push_op.block_last  = item.block_last;
        push_op.block_len   = item.block_len;
        // flag a zero-length block here so the back end only compares size
        push_op.len_zero    = (item.block_len == '0);
        push_op.stack_ready = item.stack_ready;
        push_op.stack_idle  = item.stack_idle;
        push_op.read_addr   = item.read_addr;
    end

endmodule

>>> rtl/trcs_queue.sv
// Short operation queue between the front end and the back end.
module trcs_queue import trcs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  op_t         push_op,
    input  logic        pop,
    output op_t         head_op,
    output queue_stat_t q_stat
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [QIDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_op      = entry_reg[rd_idx_reg];

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_idx_reg] <= push_op;
        end
    end

endmodule

>>> rtl/trcs_back.sv
// Back end: ring storage, pointer updates, chunk submission and result register.
module trcs_back import trcs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         head_op,
    input  queue_stat_t q_stat,
    output logic        pop,
    trcs_result_if.source result
);

    logic [DATA_W-1:0] ring_mem [RING_DEPTH];

    back_state_t       state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]  inflight_reg, inflight_next;
    logic              refused_reg, refused_next;
    logic              attempt_reg, attempt_next;
    logic              acc_reg, acc_next;
    logic              is_read_reg, is_read_next;
    logic              ready_reg, ready_next;
    logic              idle_reg, idle_next;
    logic [DATA_W-1:0] rdata_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg, out_acc_next;
    logic              out_sv_reg, out_sv_next;
    logic [PTR_W-1:0]  out_start_reg, out_start_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [PTR_W-1:0]  out_free_reg, out_free_next;
    logic [LEN_W-1:0]  out_inflight_reg, out_inflight_next;
    logic [DATA_W-1:0] out_rdata_reg, out_rdata_next;

    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  used, free;
    logic              refused;
    logic              go;
    logic [PTR_W:0]    lin_raw, lin_cap;

    assign used = wr_ptr_reg - rd_ptr_reg;
    assign free = rd_ptr_reg - wr_ptr_reg - PTR_W'(1);

    // linear run up to write pointer or ring end, capped at CHUNK_LIMIT; never longer than queued when bytes are queued
    assign lin_raw = (wr_ptr_reg > rd_ptr_reg) ? {1'b0, used}
                                               : (PTR_W + 1)'(RING_DEPTH) - {1'b0, rd_ptr_reg};
    assign lin_cap = (lin_raw > (PTR_W + 1)'(CHUNK_LIMIT)) ? (PTR_W + 1)'(CHUNK_LIMIT) : lin_raw;

    assign go = attempt_reg && ready_reg && idle_reg && (inflight_reg == '0) && (used != '0);

    always_comb
    begin
        state_next        = state_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        inflight_next     = inflight_reg;
        refused_next      = refused_reg;
        attempt_next      = attempt_reg;
        acc_next          = acc_reg;
        is_read_next      = is_read_reg;
        ready_next        = ready_reg;
        idle_next         = idle_reg;
        out_valid_next    = out_valid_reg;
        out_acc_next      = out_acc_reg;
        out_sv_next       = out_sv_reg;
        out_start_next    = out_start_reg;
        out_len_next      = out_len_reg;
        out_free_next     = out_free_reg;
        out_inflight_next = out_inflight_reg;
        out_rdata_next    = out_rdata_reg;
        pop               = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        refused           = refused_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_EXEC:
            begin
                if (!q_stat.empty)
                begin
                    pop          = 1'b1;
                    attempt_next = 1'b0;
                    acc_next     = 1'b0;
                    is_read_next = 1'b0;
                    ready_next   = head_op.stack_ready;
                    idle_next    = head_op.stack_idle;
                    state_next   = B_FINISH;
                    case (head_op.kind)
                        OP_WRITE:
                        begin
                            if (head_op.block_first)
                            begin
                                refused = head_op.len_zero
                                          || (head_op.block_len > BLEN_W'(free));
                            end
                            refused_next = refused;
                            if (!refused)
                            begin
                                acc_next     = 1'b1;
                                attempt_next = head_op.block_last;
                                // drop the byte when the ring is full
                                if (free != '0)
                                begin
                                    mem_we      = 1'b1;
                                    wr_ptr_next = wr_ptr_reg + PTR_W'(1);
                                end
                            end
                        end
                        OP_COMPLETE:
                        begin
                            rd_ptr_next   = rd_ptr_reg + PTR_W'(inflight_reg);
                            inflight_next = '0;
                            attempt_next  = 1'b1;
                        end
                        OP_KICK:
                        begin
                            attempt_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            mem_re       = 1'b1;
                            is_read_next = 1'b1;
                        end
                        default:
                        begin
                            attempt_next = 1'b0;
                        end
                    endcase
                end
            end
            B_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_acc_next      = acc_reg;
                    out_sv_next       = go;
                    out_start_next    = go ? rd_ptr_reg : '0;
                    out_len_next      = go ? LEN_W'(lin_cap) : '0;
                    out_free_next     = free;
                    out_inflight_next = go ? LEN_W'(lin_cap) : inflight_reg;
                    out_rdata_next    = is_read_reg ? rdata_reg : '0;
                    if (go)
                    begin
                        inflight_next = LEN_W'(lin_cap);
                    end
                    state_next = B_EXEC;
                end
            end
            default:
            begin
                state_next = B_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_EXEC;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            inflight_reg  <= '0;
            refused_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            inflight_reg  <= inflight_next;
            refused_reg   <= refused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        attempt_reg      <= attempt_next;
        acc_reg          <= acc_next;
        is_read_reg      <= is_read_next;
        ready_reg        <= ready_next;
        idle_reg         <= idle_next;
        out_acc_reg      <= out_acc_next;
        out_sv_reg       <= out_sv_next;
        out_start_reg    <= out_start_next;
        out_len_reg      <= out_len_next;
        out_free_reg     <= out_free_next;
        out_inflight_reg <= out_inflight_next;
        out_rdata_reg    <= out_rdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_ptr_reg] <= head_op.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= ring_mem[head_op.read_addr];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_acc_reg;
    assign result.submit_valid = out_sv_reg;
    assign result.submit_start = out_start_reg;
    assign result.submit_len   = out_len_reg;
    assign result.space_left   = out_free_reg;
    assign result.inflight_len = out_inflight_reg;
    assign result.read_data    = out_rdata_reg;

endmodule
